>>> rtl/esc_dec_pkg.sv
// Shared types, character codes and helpers for the escaped text decoder.
// No dependencies; imported by escaped_text_to_bytes_core.
package esc_dec_pkg;

  localparam int unsigned MAX_BYTES_DEF = 256;

  localparam logic [8:0] CAPACITY_RST = 9'h100;

  typedef enum logic [1:0] {
    PH_PLAIN = 2'd0,
    PH_ESC   = 2'd1,
    PH_HEX0  = 2'd2,
    PH_HEX1  = 2'd3
  } phase_t;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_HEX = 2'd1;
  localparam logic [1:0] ST_CAP = 2'd2;

  localparam logic [7:0] CH_X   = 8'h78;
  localparam logic [7:0] CH_R   = 8'h72;
  localparam logic [7:0] CH_N   = 8'h6E;
  localparam logic [7:0] CH_T   = 8'h74;
  localparam logic [7:0] CH_BSL = 8'h5C;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_TAB = 8'h09;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       done_res;
    logic [1:0] status;
    logic [8:0] byte_count;
    logic       last_of_item;
  } res_t;

  // {valid, value}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic res_t mk_byte(input logic [7:0] b);
    res_t r;
    r = '0;
    r.data_byte  = b;
    r.byte_valid = 1'b1;
    return r;
  endfunction

  function automatic res_t mk_done(input logic [1:0] st, input logic [8:0] cnt);
    res_t r;
    r = '0;
    r.done_res   = 1'b1;
    r.status     = st;
    r.byte_count = cnt;
    return r;
  endfunction

endpackage

>>> rtl/escaped_text_to_bytes_core.sv
// Escaped text decoder top level: request handshake, decode step, result buffer.
// Depends on esc_dec_pkg.
//
// Usage:
//  - Input channel (in_valid / in_stall / in_mode / in_char_code) takes one
//    request per cycle: a text character (in_mode = 0) or the end of text
//    (in_mode = 1). A request is taken when in_valid is high and in_stall low.
//  - Output channel (out_valid / out_stall / out_*) delivers decoded bytes and,
//    for each end request, a final result with status and byte count.
//    out_last_of_item marks the last result caused by one request.
//  - cfg_we / cfg_wdata write the capacity register; write it only while idle.
// Results of a request appear on the output in the cycle after it is taken.
// Throughput: one request per cycle while each request yields at most one result
//   and out_stall stays low. A request yielding two or three results (an end
//   request after a pending escape) holds off the next request until the
//   single-result output port has drained the three-entry result buffer.
// Reset (rst_n low, synchronous) clears the decode state, the result buffer and
// sets the capacity to 256. No clearing sweep follows reset.
// When the receiver stalls, results hold in the buffer and in_stall rises as
// soon as the buffer cannot take the next request's results.
module escaped_text_to_bytes_core
  import esc_dec_pkg::*;
#(
  parameter int unsigned MAX_BYTES = MAX_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [8:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_mode,
  input  logic [7:0] in_char_code,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_data_byte,
  output logic       out_byte_valid,
  output logic       out_done_res,
  output logic [1:0] out_status,
  output logic [8:0] out_byte_count,
  output logic       out_last_of_item
);

  // Count never exceeds MAX_BYTES; CNT_W covers MAX_BYTES + 2, LW covers capacity too.
  localparam int unsigned CNT_W = $clog2(MAX_BYTES + 3);
  localparam int unsigned LW    = (CNT_W > 9) ? CNT_W : 9;

  logic [8:0]       capacity_r;
  phase_t           phase_r, phase_nxt;
  logic [7:0]       held_r, held_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [1:0]       err_r, err_nxt;

  // Result buffer: entry 0 faces the output, shift down on each pop.
  res_t       res_r [3];
  logic [1:0] fill_r;

  res_t       slots [3];
  logic [1:0] k;

  logic [LW-1:0] count_ext, c1, c2, lim, cap_ext, max_ext;
  logic [4:0]    hi, lo;
  logic          pop, in_acc;

  // Output side: drive from the head of the buffer.
  assign out_valid        = (fill_r != 2'd0);
  assign out_data_byte    = res_r[0].data_byte;
  assign out_byte_valid   = res_r[0].byte_valid;
  assign out_done_res     = res_r[0].done_res;
  assign out_status       = res_r[0].status;
  assign out_byte_count   = res_r[0].byte_count;
  assign out_last_of_item = res_r[0].last_of_item;

  assign pop = out_valid && !out_stall;

  // Take a new request only when the buffer is empty after this cycle's pop.
  assign in_stall = !((fill_r == 2'd0) || (fill_r == 2'd1 && pop));
  assign in_acc   = in_valid && !in_stall;

  // Effective limit: the smaller of capacity and MAX_BYTES.
  assign cap_ext   = LW'(capacity_r);
  assign max_ext   = LW'(MAX_BYTES);
  assign lim       = (cap_ext < max_ext) ? cap_ext : max_ext;
  assign count_ext = LW'(count_r);
  assign c1        = count_ext + LW'(1);
  assign c2        = count_ext + LW'(2);
  assign hi        = hex_val(held_r);
  assign lo        = hex_val(in_char_code);

  // Decode step: next state and up to three results for the offered request.
  always_comb begin
    slots     = '{default: '0};
    k         = 2'd0;
    phase_nxt = phase_r;
    held_nxt  = held_r;
    count_nxt = count_r;
    err_nxt   = err_r;

    if (in_mode) begin
      // End of text: flush any pending escape, then report.
      if (err_r != ST_OK) begin
        slots[0] = mk_done(err_r, 9'd0);
        k        = 2'd1;
      end else begin
        unique case (phase_r)
          PH_PLAIN: begin
            slots[0] = mk_done(ST_OK, count_ext[8:0]);
            k        = 2'd1;
          end
          PH_ESC: begin
            // Trailing backslash stays literal.
            slots[0] = mk_byte(CH_BSL);
            slots[1] = mk_done(ST_OK, c1[8:0]);
            k        = 2'd2;
          end
          PH_HEX0: begin
            slots[0] = mk_byte(CH_X);
            slots[1] = mk_done(ST_OK, c1[8:0]);
            k        = 2'd2;
          end
          PH_HEX1: begin
            // Cut-short hex: x, then the held character as a new unit.
            slots[0] = mk_byte(CH_X);
            if (c1 < lim) begin
              slots[1] = mk_byte(held_r);
              slots[2] = mk_done(ST_OK, c2[8:0]);
              k        = 2'd3;
            end else begin
              slots[1] = mk_done(ST_CAP, 9'd0);
              k        = 2'd2;
            end
          end
          default: ;
        endcase
      end
      phase_nxt = PH_PLAIN;
      held_nxt  = 8'd0;
      count_nxt = '0;
      err_nxt   = ST_OK;
    end else if (err_r == ST_OK) begin
      unique case (phase_r)
        PH_PLAIN: begin
          priority if (count_ext >= lim) begin
            err_nxt = ST_CAP;
          end else if (in_char_code == CH_BSL) begin
            phase_nxt = PH_ESC;
          end else begin
            slots[0]  = mk_byte(in_char_code);
            k         = 2'd1;
            count_nxt = c1[CNT_W-1:0];
          end
        end
        PH_ESC: begin
          phase_nxt = PH_PLAIN;
          k         = 2'd1;
          count_nxt = c1[CNT_W-1:0];
          priority if (in_char_code == CH_R) begin
            slots[0] = mk_byte(CH_CR);
          end else if (in_char_code == CH_N) begin
            slots[0] = mk_byte(CH_LF);
          end else if (in_char_code == CH_T) begin
            slots[0] = mk_byte(CH_TAB);
          end else if (in_char_code == CH_X) begin
            phase_nxt = PH_HEX0;
            k         = 2'd0;
            count_nxt = count_r;
          end else begin
            slots[0] = mk_byte(in_char_code);
          end
        end
        PH_HEX0: begin
          held_nxt  = in_char_code;
          phase_nxt = PH_HEX1;
        end
        PH_HEX1: begin
          phase_nxt = PH_PLAIN;
          held_nxt  = 8'd0;
          if (!hi[4] || !lo[4]) begin
            err_nxt = ST_HEX;
          end else begin
            slots[0]  = mk_byte({hi[3:0], lo[3:0]});
            k         = 2'd1;
            count_nxt = c1[CNT_W-1:0];
          end
        end
        default: ;
      endcase
    end
    // Sticky error on a character request: drop it, no results.

    if (k != 2'd0) begin
      slots[k - 2'd1].last_of_item = 1'b1;
    end
  end

  // Capacity register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAPACITY_RST;
    end else if (cfg_we) begin
      capacity_r <= cfg_wdata;
    end
  end

  // Decode state: advance on each taken request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PLAIN;
      held_r  <= 8'd0;
      count_r <= '0;
      err_r   <= ST_OK;
    end else if (in_acc) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      count_r <= count_nxt;
      err_r   <= err_nxt;
    end
  end

  // Result buffer fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 2'd0;
    end else if (in_acc) begin
      fill_r <= k;
    end else if (pop) begin
      fill_r <= fill_r - 2'd1;
    end
  end

  // Result buffer payload: load fresh results, or shift down on pop.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r[0] <= slots[0];
      res_r[1] <= slots[1];
      res_r[2] <= slots[2];
    end else if (pop) begin
      res_r[0] <= res_r[1];
      res_r[1] <= res_r[2];
    end
  end

  // An end request returns the decoder to a clean state.
  a_end_clears : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_mode |=> phase_r == PH_PLAIN && count_r == '0 && err_r == ST_OK)
    else $error("end request did not clear decode state");

  // With a sticky error, a character request yields nothing.
  a_err_silent : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_mode && err_r != ST_OK |=> fill_r == 2'd0 && err_r == $past(err_r))
    else $error("character produced results under a sticky error");

  // The final entry left in the buffer closes its request.
  a_last_marked : assert property (@(posedge clk) disable iff (!rst_n)
    fill_r == 2'd1 |-> res_r[0].last_of_item)
    else $error("last buffered result lacks last_of_item");

  // Any done result with an error carries a zero count.
  a_err_count : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res && out_status != ST_OK |-> out_byte_count == 9'd0)
    else $error("error report carries a byte count");

endmodule
